>>> src/ucd_pkg.sv
`default_nettype none
package ucd_pkg;
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_ROOT,
      ST_SCAN,
      ST_CHECK,
      ST_POP,
      ST_CLEAR,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

>>> src/undirected_cycle_detect.sv
`default_nettype none
// Undirected cycle check. Edges arrive one word per cycle, while req_tready is high,
// on the req_ channel (tdata: first_node, second_node; tlast: last_edge); those with
// both nodes below MAX_NODES are written into an edge memory while it has room. The
// word with tlast high starts a depth-first search from every unvisited node below
// node_count, using an explicit stack of (node, entry edge, scan position). The
// search reads each edge from the single-port edge memory and then compares it;
// returning to a parent goes through a pop state for the registered stack read.
// After the search the visited bits are cleared. req_tready is low during the
// search and until the result word (tdata: has_cycle, edge_overflow) is taken on
// the rsp_ channel.
module undirected_cycle_detect #(
   parameter int MAX_NODES = 64,
   parameter int MAX_EDGES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [6:0]  csr_wr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [5:0] first_node, [11:6] second_node
   input  wire logic        req_tlast,   // last_edge
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata    // [0] has_cycle, [1] edge_overflow
);
   import ucd_pkg::*;

   localparam int NW = $clog2(MAX_NODES);
   localparam int EW = $clog2(MAX_EDGES) + 1;  // holds MAX_EDGES itself
   localparam int SW = $clog2(MAX_NODES + 1);
   localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

   state_type  state_ff, state_in;
   logic [6:0] count_ff;
   logic [EW-1:0] total_ff, total_in;
   logic drop_ff, drop_in, cyc_ff, cyc_in;
   logic [NW:0] root_ff, root_in;
   logic [SW-1:0] lvl_ff, lvl_in;
   logic [MAX_NODES-1:0] vis_ff;
   logic vis_set, vis_clr;
   logic [NW-1:0] vis_idx;

   // edge memory
   logic [11:0] edge_mem [MAX_EDGES];
   logic [11:0] edge_rd;
   logic        ed_we;
   logic [AW-1:0] ed_addr;
   // stack memory: node, entry edge, scan position
   logic [NW-1:0] stk_node [MAX_NODES];
   logic [EW-1:0] stk_from [MAX_NODES];
   // top-of-stack copy kept in registers
   logic [NW-1:0] here_ff, here_in;
   logic [EW-1:0] from_ff, from_in, pos_ff, pos_in;
   logic [EW-1:0] spos [MAX_NODES];
   logic push;
   // registered read of the parent entry
   logic [NW-1:0] stk_raddr;
   logic [NW-1:0] pop_node;
   logic [EW-1:0] pop_from, pop_pos;

   logic [5:0] a_in, b_in;
   logic a_ok, b_ok;
   assign a_in = req_tdata[5:0];
   assign b_in = req_tdata[11:6];
   assign a_ok = 32'(a_in) < MAX_NODES;
   assign b_ok = 32'(b_in) < MAX_NODES;

   logic req_fire;
   assign req_fire = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = (state_ff == ST_DONE);
   assign rsp_tdata = {6'd0, drop_ff, cyc_ff};

   logic [NW:0] limit;
   assign limit = (32'(count_ff) > MAX_NODES) ? (NW+1)'(MAX_NODES) : (NW+1)'(count_ff);

   // compare unit on the fetched edge
   logic [NW-1:0] e_lo, e_hi, other;
   logic hit;
   assign e_lo = NW'(edge_rd[5:0]);
   assign e_hi = NW'(edge_rd[11:6]);
   always_comb begin
      hit = 1'b1;
      other = e_hi;
      if (e_lo == here_ff) other = e_hi;
      else if (e_hi == here_ff) other = e_lo;
      else hit = 1'b0;
   end
   logic [EW-1:0] cur_e;
   assign cur_e = pos_ff - EW'(1);

   assign ed_we = req_fire && a_ok && b_ok && (32'(total_ff) < MAX_EDGES);
   assign ed_addr = ed_we ? AW'(total_ff) : AW'(pos_ff);

   always_ff @(posedge clock) begin
      if (ed_we) edge_mem[ed_addr] <= {b_in[5:0], a_in[5:0]};
      edge_rd <= edge_mem[ed_addr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:  if (req_fire && req_tlast) state_in = ST_ROOT;
         ST_ROOT:  if (root_ff >= limit) state_in = ST_CLEAR;
                   else if (!vis_ff[NW'(root_ff)]) state_in = ST_SCAN;
         ST_SCAN:  if (pos_ff >= total_ff) state_in = (lvl_ff == SW'(1)) ? ST_ROOT : ST_POP;
                   else state_in = ST_CHECK;
         ST_CHECK: if (hit && cur_e != from_ff && vis_ff[other]) state_in = ST_CLEAR;
                   else state_in = ST_SCAN;
         ST_POP:   state_in = ST_SCAN;
         ST_CLEAR: if (root_ff == (NW+1)'(MAX_NODES - 1)) state_in = ST_DONE;
         ST_DONE:  if (rsp_tready) state_in = ST_LOAD;
         default:  state_in = ST_LOAD;
      endcase
   end

   // datapath control
   always_comb begin
      total_in = total_ff; drop_in = drop_ff; cyc_in = cyc_ff; root_in = root_ff;
      lvl_in = lvl_ff; here_in = here_ff; from_in = from_ff; pos_in = pos_ff;
      vis_set = 1'b0; vis_clr = 1'b0; vis_idx = NW'(root_ff); push = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (ed_we) total_in = total_ff + EW'(1);
            else if (req_fire && a_ok && b_ok) drop_in = 1'b1;
            root_in = '0; cyc_in = 1'b0;
         end
         ST_ROOT: begin
            if (root_ff >= limit) root_in = '0;
            else if (!vis_ff[NW'(root_ff)]) begin
               vis_set = 1'b1; here_in = NW'(root_ff); from_in = EW'(MAX_EDGES);
               pos_in = '0; lvl_in = SW'(1);
            end else root_in = root_ff + (NW+1)'(1);
         end
         ST_SCAN: begin
            if (pos_ff >= total_ff) begin
               lvl_in = lvl_ff - SW'(1);
               if (lvl_ff == SW'(1)) root_in = root_ff + (NW+1)'(1);
            end else pos_in = pos_ff + EW'(1);
         end
         ST_CHECK: begin
            if (hit && cur_e != from_ff) begin
               if (vis_ff[other]) begin cyc_in = 1'b1; root_in = '0; end
               else if (32'(lvl_ff) < MAX_NODES) begin
                  push = 1'b1; vis_set = 1'b1; vis_idx = other;
                  here_in = other; from_in = cur_e; pos_in = '0;
                  lvl_in = lvl_ff + SW'(1);
               end
            end
         end
         ST_POP: begin
            // parent entry comes back from the stack memory
            here_in = pop_node; from_in = pop_from; pos_in = pop_pos;
         end
         ST_CLEAR: begin
            vis_clr = 1'b1; root_in = root_ff + (NW+1)'(1);
            total_in = '0; lvl_in = '0;
         end
         ST_DONE: if (rsp_tready) drop_in = 1'b0;
         default: ;
      endcase
   end

   // stack: save parent's entry when a child is pushed, read the parent back
   assign stk_raddr = NW'(lvl_ff - SW'(2));
   always_ff @(posedge clock) begin
      if (push) begin
         stk_node[NW'(lvl_ff - SW'(1))] <= here_ff;
         stk_from[NW'(lvl_ff - SW'(1))] <= from_ff;
         spos[NW'(lvl_ff - SW'(1))] <= pos_ff;
      end
      pop_node <= stk_node[stk_raddr];
      pop_from <= stk_from[stk_raddr];
      pop_pos  <= spos[stk_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD; count_ff <= 7'd64; total_ff <= '0; drop_ff <= 1'b0;
         cyc_ff <= 1'b0; root_ff <= '0; lvl_ff <= '0; vis_ff <= '0;
      end else begin
         state_ff <= state_in; total_ff <= total_in; drop_ff <= drop_in;
         cyc_ff <= cyc_in; root_ff <= root_in; lvl_ff <= lvl_in;
         if (csr_wr_en) count_ff <= csr_wr_data;
         if (vis_set) vis_ff[vis_idx] <= 1'b1;
         if (vis_clr) vis_ff[NW'(root_ff)] <= 1'b0;
      end
      here_ff <= here_in; from_ff <= from_in; pos_ff <= pos_in;
   end
endmodule
`default_nettype wire

>>> src/ucd_checker.sv
`default_nettype none
module ucd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       req_tlast,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata
);
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accepting while result pending");
   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready) else $error("no stall");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata)) else $error("drop");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:2] == 6'd0) else $error("pad");
endmodule
bind undirected_cycle_detect ucd_checker u_chk (.*);
`default_nettype wire
